// ----- design/dlef_pkg.sv -----
// Shared types, register codes, reset values and saturation helper for the echo filter.
package dlef_pkg;

    localparam int SAMPLE_W = 12;
    localparam int GAIN_W   = 16;
    localparam int LEN_W    = 14;
    localparam int DATA_W   = 16;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [GAIN_W-1:0]   FB_GAIN_RST    = 16'd45875;
    localparam logic [GAIN_W-1:0]   OUT_GAIN_RST   = 16'd33423;
    localparam logic [SAMPLE_W-1:0] MID_OFFSET_RST = 12'd2047;
    localparam logic [LEN_W-1:0]    DELAY_LEN_RST  = 14'd5000;

    typedef enum logic [1:0] {
        REG_FB_GAIN    = 2'd0,
        REG_OUT_GAIN   = 2'd1,
        REG_MID_OFFSET = 2'd2,
        REG_DELAY_LEN  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]   feedback_gain;
        logic [GAIN_W-1:0]   output_gain;
        logic [SAMPLE_W-1:0] mid_offset;
        logic [LEN_W-1:0]    delay_length;
    } dlef_cfg_t;

    // Clamp an 18-bit signed value into signed 16 bits.
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [17:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/delay_line_echo_filter.sv -----
// Top level: pipelined feedback comb echo filter over a circular delay line.
//
//  channel  | handshake          | payload        | role
//  ---------+--------------------+----------------+-------------------------------
//  s_       | s_valid / s_ready  | s_sample[11:0] | converter sample, one per item
//  m_       | m_valid / m_ready  | m_dac_value    | clamped DAC value, one per item
//  apb      | psel/penable/...   | pwdata/prdata  | gains, offset, delay length
//
//  Throughput: one item per cycle while the effective delay length is 2 or
//  more and m_ready does not stall the pipe; at length 1 each item waits on the
//  previous one's feedback product. Items pass the S1 to S4 registers to m_valid.
//  Reset: after aresetn the delay memory is swept to zero, one entry per cycle,
//  with s_ready low until every entry is cleared; APB writes are taken throughout.
//  Stalls: m_ready low freezes the pipe stage by stage; bubbles are squeezed out,
//  nothing is dropped or repeated.
//
//  Pipe:  S1 memory data + forwarding, sum and saturate
//         S2 two 16x17 multiplies (feedback product, net output gain product)
//         S3 truncate/saturate write-back value, floor/clamp output, memory write
//         S4 output register
module delay_line_echo_filter import dlef_pkg::*; #(
    parameter int DELAY_MAX = 8192
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SAMPLE_W-1:0] m_dac_value,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int PTR_W     = $clog2(DELAY_MAX);
    localparam int LEN_CMP_W = (PTR_W + 1 > LEN_W) ? PTR_W + 1 : LEN_W;

    dlef_cfg_t cfg;

    dlef_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- delay memory and clearing sweep ----------------
    logic [DATA_W-1:0] dly_mem [0:DELAY_MAX-1];

    logic             clr_busy_reg;
    logic [PTR_W-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == PTR_W'(DELAY_MAX - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // ---------------- pipeline registers ----------------
    logic                     s1_valid_reg, s1_valid_next;
    logic [SAMPLE_W-1:0]      s1_sample_reg;
    logic [PTR_W-1:0]         s1_idx_reg;
    logic [DATA_W-1:0]        s1_rd_reg;
    logic                     s1_ov_valid_reg;
    logic [DATA_W-1:0]        s1_ov_data_reg;

    logic                     s2_valid_reg;
    logic [PTR_W-1:0]         s2_idx_reg;
    logic signed [DATA_W-1:0] s2_sum_reg;

    logic                     s3_valid_reg;
    logic [PTR_W-1:0]         s3_idx_reg;
    logic signed [32:0]       s3_fb_prod_reg;
    logic signed [32:0]       s3_net_prod_reg;

    logic                     s4_valid_reg;
    logic [SAMPLE_W-1:0]      s4_dac_reg;

    logic [PTR_W-1:0]         ptr_reg, ptr_next;

    // ---------------- flow control ----------------
    logic s4_free, s3_free, s2_free, s1_free;
    logic s3_move, s2_move, s1_move;
    logic hazard, accept;

    assign s4_free = !s4_valid_reg || m_ready;
    assign s3_move = s3_valid_reg && s4_free;
    assign s3_free = !s3_valid_reg || s4_free;
    assign s2_move = s2_valid_reg && s3_free;
    assign s2_free = !s2_valid_reg || s3_free;
    // The item right ahead on the same entry has no write-back value yet: hold until it reaches S3.
    assign hazard  = s1_valid_reg && s2_valid_reg && (s2_idx_reg == s1_idx_reg);
    assign s1_move = s1_valid_reg && s2_free && !hazard;
    assign s1_free = !s1_valid_reg || s1_move;
    assign s_ready = s1_free && !clr_busy_reg;
    assign accept  = s_valid && s_ready;

    assign s1_valid_next = accept || (s1_valid_reg && !s1_move);

    // ---------------- pointer ----------------
    logic [LEN_CMP_W-1:0] len_ext, eff_len, ptr_inc;

    always_comb begin
        len_ext = LEN_CMP_W'(cfg.delay_length);
        if (len_ext == '0) begin
            eff_len = LEN_CMP_W'(1);
        end else if (len_ext > LEN_CMP_W'(DELAY_MAX)) begin
            eff_len = LEN_CMP_W'(DELAY_MAX);
        end else begin
            eff_len = len_ext;
        end
        ptr_inc = LEN_CMP_W'(ptr_reg) + 1'b1;
        if (ptr_inc >= eff_len) begin
            ptr_next = '0;
        end else begin
            ptr_next = ptr_inc[PTR_W-1:0];
        end
    end

    // ---------------- S3 combinational: write-back and output ----------------
    logic signed [16:0]       s3_q;
    logic signed [DATA_W-1:0] s3_store;
    logic signed [33:0]       s3_y_full;
    logic [SAMPLE_W-1:0]      s3_dac;

    always_comb begin
        // truncate toward zero: floor, then bump negatives that had a fraction
        s3_q = s3_fb_prod_reg[32:16];
        if (s3_fb_prod_reg[32] && (s3_fb_prod_reg[15:0] != '0)) begin
            s3_q = s3_q + 17'sd1;
        end
        s3_store = sat16({s3_q[16], s3_q});

        s3_y_full = {s3_net_prod_reg[32], s3_net_prod_reg}
                  + $signed({6'b0, cfg.mid_offset, 16'b0});
        if (s3_y_full[33]) begin
            s3_dac = '0;
        end else if (s3_y_full[32:28] != '0) begin
            s3_dac = '1;
        end else begin
            s3_dac = s3_y_full[27:16];
        end
    end

    // ---------------- S1 combinational: forwarding and sum ----------------
    logic                     fwd_s3;
    logic [DATA_W-1:0]        s1_stored;
    logic signed [17:0]       s1_sum_wide;
    logic signed [DATA_W-1:0] s1_sum;

    always_comb begin
        fwd_s3 = s3_valid_reg && (s3_idx_reg == s1_idx_reg);
        if (fwd_s3) begin
            s1_stored = s3_store;
        end else if (s1_ov_valid_reg) begin
            s1_stored = s1_ov_data_reg;
        end else begin
            s1_stored = s1_rd_reg;
        end
        s1_sum_wide = $signed({6'b0, s1_sample_reg}) - $signed({6'b0, cfg.mid_offset})
                    + $signed({{2{s1_stored[DATA_W-1]}}, s1_stored});
        s1_sum = sat16(s1_sum_wide);
    end

    // ---------------- S2 combinational: products ----------------
    logic signed [16:0] net_gain;
    logic signed [32:0] s2_fb_prod, s2_net_prod;

    assign net_gain    = $signed({1'b0, cfg.output_gain}) - $signed({1'b0, cfg.feedback_gain});
    assign s2_fb_prod  = $signed({{17{s2_sum_reg[DATA_W-1]}}, s2_sum_reg})
                       * $signed({17'b0, cfg.feedback_gain});
    assign s2_net_prod = $signed({{17{s2_sum_reg[DATA_W-1]}}, s2_sum_reg})
                       * $signed({{16{net_gain[16]}}, net_gain});

    // ---------------- memory port ----------------
    logic              mem_wr_en;
    logic [PTR_W-1:0]  mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;

    assign mem_wr_en   = clr_busy_reg || s3_move;
    assign mem_wr_addr = clr_busy_reg ? clr_addr_reg : s3_idx_reg;
    assign mem_wr_data = clr_busy_reg ? '0 : s3_store;

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            dly_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (accept) begin
            s1_rd_reg <= dly_mem[ptr_reg];
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            s1_ov_valid_reg <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                ptr_reg <= ptr_next;
            end
            s1_valid_reg <= s1_valid_next;
            // snoop write-backs that land after the memory read of the S1 item
            if (accept) begin
                s1_ov_valid_reg <= s3_move && (s3_idx_reg == ptr_reg);
            end else if (s1_valid_reg && s3_move && (s3_idx_reg == s1_idx_reg)) begin
                s1_ov_valid_reg <= 1'b1;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_move;
            end
            if (s3_free) begin
                s3_valid_reg <= s2_move;
            end
            if (s4_free) begin
                s4_valid_reg <= s3_move;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sample_reg  <= s_sample;
            s1_idx_reg     <= ptr_reg;
            s1_ov_data_reg <= s3_store;
        end else if (s1_valid_reg && s3_move && (s3_idx_reg == s1_idx_reg)) begin
            s1_ov_data_reg <= s3_store;
        end
        if (s1_move) begin
            s2_idx_reg <= s1_idx_reg;
            s2_sum_reg <= s1_sum;
        end
        if (s2_move) begin
            s3_idx_reg      <= s2_idx_reg;
            s3_fb_prod_reg  <= s2_fb_prod;
            s3_net_prod_reg <= s2_net_prod;
        end
        if (s3_move) begin
            s4_dac_reg <= s3_dac;
        end
    end

    assign m_valid     = s4_valid_reg;
    assign m_dac_value = s4_dac_reg;

endmodule

// ----- design/dlef_apb.sv -----
// APB register file holding the filter configuration.
module dlef_apb import dlef_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output dlef_cfg_t         cfg
);

    dlef_cfg_t cfg_reg;
    reg_idx_t  reg_idx;
    logic      wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.feedback_gain <= FB_GAIN_RST;
            cfg_reg.output_gain   <= OUT_GAIN_RST;
            cfg_reg.mid_offset    <= MID_OFFSET_RST;
            cfg_reg.delay_length  <= DELAY_LEN_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FB_GAIN:    cfg_reg.feedback_gain <= pwdata[GAIN_W-1:0];
                REG_OUT_GAIN:   cfg_reg.output_gain   <= pwdata[GAIN_W-1:0];
                REG_MID_OFFSET: cfg_reg.mid_offset    <= pwdata[SAMPLE_W-1:0];
                REG_DELAY_LEN:  cfg_reg.delay_length  <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FB_GAIN:    prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg_reg.feedback_gain};
            REG_OUT_GAIN:   prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg_reg.output_gain};
            REG_MID_OFFSET: prdata = {{(APB_DW-SAMPLE_W){1'b0}}, cfg_reg.mid_offset};
            REG_DELAY_LEN:  prdata = {{(APB_DW-LEN_W){1'b0}}, cfg_reg.delay_length};
            default:        prdata = '0;
        endcase
    end

endmodule

// ----- bench/dlef_checker.sv -----
// Echo filter checker: watches the sample, result and register ports, predicts and compares.
`timescale 1ns / 100ps

module dlef_checker import dlef_pkg::*; #(
    parameter int DELAY_MAX = 8192
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [SAMPLE_W-1:0] m_dac_value,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output int                  err_count,
    output int                  pending
);

    logic signed [DATA_W-1:0] echo_mem [DELAY_MAX];
    int unsigned              tap_idx;
    logic [GAIN_W-1:0]        fb_gain;
    logic [GAIN_W-1:0]        out_gain;
    logic [SAMPLE_W-1:0]      mid_ofs;
    logic [LEN_W-1:0]         dly_len;
    logic [SAMPLE_W-1:0]      dac_q [$];

    function automatic longint clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // One step of the comb: read tap, write back feedback, advance pointer.
    function automatic logic [SAMPLE_W-1:0] filter_sample(input logic [SAMPLE_W-1:0] smp);
        longint      sum;
        longint      fb_prod;
        longint      og_prod;
        longint      wb;
        longint      y_full;
        longint      y;
        int unsigned len;
        sum = clamp16(longint'(smp) - longint'(mid_ofs) + longint'(echo_mem[tap_idx]));
        fb_prod = sum * longint'(fb_gain);
        og_prod = sum * longint'(out_gain);
        // write-back truncates toward zero
        wb = (fb_prod >= 0) ? (fb_prod >>> 16) : -((-fb_prod) >>> 16);
        echo_mem[tap_idx] = DATA_W'(clamp16(wb));
        // output floors, then clamps to the DAC range
        y_full = og_prod - fb_prod + (longint'(mid_ofs) <<< 16);
        if (y_full < 0) begin
            y = 0;
        end else begin
            y = y_full >>> 16;
            if (y > 4095) y = 4095;
        end
        if (dly_len == 0) len = 1;
        else if (dly_len > DELAY_MAX) len = DELAY_MAX;
        else len = dly_len;
        tap_idx = (tap_idx + 1 >= len) ? 0 : tap_idx + 1;
        return SAMPLE_W'(y);
    endfunction

    always @(posedge aclk) begin
        logic [SAMPLE_W-1:0] want;
        if (!aresetn) begin
            foreach (echo_mem[i]) echo_mem[i] = '0;
            tap_idx   = 0;
            fb_gain   = FB_GAIN_RST;
            out_gain  = OUT_GAIN_RST;
            mid_ofs   = MID_OFFSET_RST;
            dly_len   = DELAY_LEN_RST;
            dac_q.delete();
            err_count <= 0;
        end else begin
            if (s_valid && s_ready) dac_q.push_back(filter_sample(s_sample));
            if (m_valid && m_ready) begin
                if (dac_q.size() == 0) begin
                    $display("%0t: unexpected item, expected none, got dac_value %0d",
                             $time, m_dac_value);
                    err_count <= err_count + 1;
                end else begin
                    want = dac_q.pop_front();
                    if (m_dac_value !== want) begin
                        $display("%0t: dac_value mismatch, expected %0d, got %0d",
                                 $time, want, m_dac_value);
                        err_count <= err_count + 1;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_FB_GAIN:    fb_gain  = pwdata[GAIN_W-1:0];
                    REG_OUT_GAIN:   out_gain = pwdata[GAIN_W-1:0];
                    REG_MID_OFFSET: mid_ofs  = pwdata[SAMPLE_W-1:0];
                    REG_DELAY_LEN:  dly_len  = pwdata[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
        pending <= dac_q.size();
    end

endmodule

// ----- bench/tb_delay_line_echo_filter.sv -----
// Testbench top for the echo filter: clock, reset, stimulus, pressure and verdict.
`timescale 1ns / 100ps

module tb_delay_line_echo_filter;
    import dlef_pkg::*;

    localparam int DELAY_MAX       = 8192;
    localparam int RAND_PHASES     = 9;
    localparam int ITEMS_PER_PHASE = 48;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int LATENCY_PAD     = 8;
    // the memory sweep after reset keeps s_ready low until every delay entry is cleared
    localparam int WATCHDOG_LIMIT  = 5 * DELAY_MAX;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_sample;
    logic                m_valid;
    logic                m_ready;
    logic [SAMPLE_W-1:0] m_dac_value;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int   err_count;
    int   pending;
    int   stall_cycles;
    logic burst_mode;    // both sides run with no idle cycles
    logic rx_hold_req;   // ask the receiver for its one long hold-off
    logic rx_hold_done;

    delay_line_echo_filter #(.DELAY_MAX(DELAY_MAX)) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dac_value (m_dac_value),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    dlef_checker #(.DELAY_MAX(DELAY_MAX)) u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dac_value (m_dac_value),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .err_count   (err_count),
        .pending     (pending)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: any stretch with no item moving on either side is bounded.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random backpressure, plus one long hold-off so the pipe
    // fills and s_ready drops while the sender keeps offering items.
    initial begin
        m_ready      <= 1'b0;
        rx_hold_done  = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req && !rx_hold_done) begin
                rx_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= burst_mode || ($urandom_range(0, 99) >= 30);
        end
    end

    // Two-phase register write; it always returns to an idle bus (psel low) so
    // back-to-back writes never drive psel twice in one step.
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [APB_DW-1:0] fb, input logic [APB_DW-1:0] og,
                             input logic [APB_DW-1:0] mid, input logic [APB_DW-1:0] len);
        write_reg(REG_FB_GAIN, fb);
        write_reg(REG_OUT_GAIN, og);
        write_reg(REG_MID_OFFSET, mid);
        write_reg(REG_DELAY_LEN, len);
    endtask

    // Offer one item, with random idle cycles in front unless bursting.
    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        while (!burst_mode && $urandom_range(0, 99) < 30) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Sender pauses until every expected item is back, then lets the
    // pipe settle before any register is touched.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY_PAD) @(posedge aclk);
    endtask

    // Upper pwdata bits are random: registers only keep their own width.
    function automatic logic [APB_DW-1:0] pick_gain();
        logic [APB_DW-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 4))
            0:       r[GAIN_W-1:0] = '0;
            1:       r[GAIN_W-1:0] = '1;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [APB_DW-1:0] pick_mid();
        logic [APB_DW-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 4))
            0:       r[SAMPLE_W-1:0] = '0;
            1:       r[SAMPLE_W-1:0] = '1;
            2:       r[SAMPLE_W-1:0] = 12'd2047;
            default: ;
        endcase
        return r;
    endfunction

    // Mostly short lines so stored echoes come back around quickly.
    function automatic logic [APB_DW-1:0] pick_len();
        logic [APB_DW-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       r[LEN_W-1:0] = '0;
            1:       r[LEN_W-1:0] = 14'd1;
            2:       r[LEN_W-1:0] = 14'd2;
            3:       r[LEN_W-1:0] = 14'(DELAY_MAX);
            4:       r[LEN_W-1:0] = 14'($urandom_range(41, DELAY_MAX - 1));
            5:       r[LEN_W-1:0] = 14'($urandom_range(DELAY_MAX + 1, 16383));
            default: r[LEN_W-1:0] = 14'($urandom_range(3, 40));
        endcase
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [APB_DW-1:0] len_w;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_sample     <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        burst_mode   <= 1'b0;
        rx_hold_req  <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset gains and length; alternating bit patterns
        send_sample(12'h000);
        send_sample(12'hFFF);
        send_sample(12'hAAA);
        send_sample(12'h555);
        drain();

        // length zero with the pointer left past it: entry 4 once, then
        // entry 0 over and over; full feedback drives the sum to negative
        // saturation and zero output gain pushes the output above full scale
        write_cfg(32'h0000_FFFF, 32'h0, 32'd4095, 32'd0);
        repeat (10) send_sample(12'h000);
        drain();

        // length above the line size; unity output gain, no feedback:
        // a saturated tap floors below zero, then a positive tap overshoots
        write_cfg(32'h0, 32'h0000_FFFF, 32'h0, 32'd16383);
        send_sample(12'h000);
        send_sample(12'hFFF);
        drain();

        // single entry, full feedback, full-scale input: positive saturation
        write_cfg(32'h0000_FFFF, 32'h0000_8000, 32'h0, 32'd1);
        repeat (10) send_sample(12'hFFF);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            len_w = pick_len();
            if (ph == 0) len_w[LEN_W-1:0] = 14'd16383;
            if (ph == 1) len_w[LEN_W-1:0] = 14'(DELAY_MAX);
            write_cfg(pick_gain(), pick_gain(), pick_mid(), len_w);
            burst_mode <= (ph == 2);
            if (ph == 5) rx_hold_req <= 1'b1;
            repeat (ITEMS_PER_PHASE) send_sample(pick_sample());
            drain();
        end

        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- delay_line_echo_filter.f -----
design/dlef_pkg.sv
design/dlef_apb.sv
design/delay_line_echo_filter.sv
bench/dlef_checker.sv
bench/tb_delay_line_echo_filter.sv
